[hw/rtl/rpxy_pkg.sv]
package rpxy_pkg;

  localparam int AngleBits        = 16;
  localparam int CordicIters      = 24;
  localparam int CordicW          = 34;
  localparam int TrigW            = 18;
  localparam int TrigFrac         = 16;
  localparam int CoordW           = 32;
  localparam int ProdW            = CoordW + TrigW;
  localparam int AccW             = ProdW + 2;
  localparam int FifoDepthDefault = 4;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [TrigW-1:0]   TrigOne    = 18'sd65536;

  // atan(2^-i), 2^32 is a full turn
  localparam logic signed [CordicW-1:0] AtanTab [CordicIters] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10680350,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [TrigW-1:0]  trig_t;

  typedef struct packed {
    coord_t      point_x;
    coord_t      point_y;
    coord_t      point_z;
    logic [15:0] angle_alpha;
    logic [15:0] angle_beta;
  } in_item_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
  } out_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    trig_t  ca;
    trig_t  sa;
    trig_t  cb;
    trig_t  sb;
  } trig_item_t;

endpackage

[hw/rtl/rpxy_chan_if.sv]
interface rpxy_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rpxy_front.sv]
module rpxy_front import rpxy_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpxy_chan_if.sink    in_i,
  rpxy_chan_if.source  out_o
);

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic [1:0]                q;
  } lane_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
  } pt_t;

  localparam logic signed [CordicW-1:0] TinyLim = 34'sd16384;
  localparam logic signed [CordicW-1:0] RndHalf = 34'sd8192;
  localparam logic signed [CordicW-1:0] ClampHi = 34'sd65536;

  function automatic lane_t init_lane(input logic [15:0] ang);
    lane_t      l;
    logic [31:0] a;
    logic [31:0] ru;
    logic [1:0]  q;
    a    = (32'(ang) & ((32'd1 << AngleBits) - 32'd1)) << (32 - AngleBits);
    q    = 2'((a + 32'h2000_0000) >> 30);
    ru   = a - {q, 30'd0};
    l.x  = CordicGain;
    l.y  = '0;
    l.z  = {{(CordicW-32){ru[31]}}, ru};
    l.q  = q;
    return l;
  endfunction

  function automatic lane_t cordic_step(input lane_t l, input int unsigned i);
    lane_t r;
    logic signed [CordicW-1:0] dx;
    logic signed [CordicW-1:0] dy;
    dx  = l.y >>> i;
    dy  = l.x >>> i;
    r.q = l.q;
    if (!l.z[CordicW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - AtanTab[i];
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + AtanTab[i];
    end
    return r;
  endfunction

  function automatic trig_t to_trig(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] r;
    r = (v + RndHalf) >>> 14;
    if (v > -TinyLim && v < TinyLim) begin
      r = '0;
    end else if (r > ClampHi) begin
      r = ClampHi;
    end else if (r < -ClampHi) begin
      r = -ClampHi;
    end
    return TrigW'(r);
  endfunction

  // Fold the quadrant back: returns {cos, sin}
  function automatic logic [2*TrigW-1:0] fold(input lane_t l);
    trig_t c;
    trig_t s;
    logic [2*TrigW-1:0] r;
    c = to_trig(l.x);
    s = to_trig(l.y);
    case (l.q)
      2'd0:    r = {c, s};
      2'd1:    r = {trig_t'(-s), c};
      2'd2:    r = {trig_t'(-c), trig_t'(-s)};
      default: r = {s, trig_t'(-c)};
    endcase
    return r;
  endfunction

  lane_t      la_q [CordicIters+1];
  lane_t      lb_q [CordicIters+1];
  pt_t        pt_q [CordicIters+1];
  logic       vld_q [CordicIters+1];
  trig_item_t fin_q;
  logic       fin_vld_q;
  logic       adv;
  logic [2*TrigW-1:0] cs_a;
  logic [2*TrigW-1:0] cs_b;

  // Advance the whole front unless the finished item is blocked
  assign adv         = !fin_vld_q || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = fin_vld_q;
  assign out_o.data  = fin_q;

  assign cs_a = fold(la_q[CordicIters]);
  assign cs_b = fold(lb_q[CordicIters]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= CordicIters; i++) begin
        vld_q[i] <= 1'b0;
      end
      fin_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_i.valid;
      for (int i = 0; i < CordicIters; i++) begin
        vld_q[i+1] <= vld_q[i];
      end
      fin_vld_q <= vld_q[CordicIters];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      la_q[0] <= init_lane(in_i.data.angle_alpha);
      lb_q[0] <= init_lane(in_i.data.angle_beta);
      pt_q[0] <= '{px: in_i.data.point_x, py: in_i.data.point_y, pz: in_i.data.point_z};
      for (int i = 0; i < CordicIters; i++) begin
        la_q[i+1] <= cordic_step(la_q[i], i);
        lb_q[i+1] <= cordic_step(lb_q[i], i);
        pt_q[i+1] <= pt_q[i];
      end
      fin_q.point_x <= pt_q[CordicIters].px;
      fin_q.point_y <= pt_q[CordicIters].py;
      fin_q.point_z <= pt_q[CordicIters].pz;
      fin_q.ca      <= cs_a[2*TrigW-1:TrigW];
      fin_q.sa      <= cs_a[TrigW-1:0];
      fin_q.cb      <= cs_b[2*TrigW-1:TrigW];
      fin_q.sb      <= cs_b[TrigW-1:0];
    end
  end

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q |-> (fin_q.ca <= TrigOne && fin_q.ca >= -TrigOne &&
                   fin_q.sb <= TrigOne && fin_q.sb >= -TrigOne))
    else $error("trig value out of range");

endmodule

[hw/rtl/rpxy_fifo.sv]
module rpxy_fifo import rpxy_pkg::*; #(
  parameter int Depth = FifoDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpxy_chan_if.sink    in_i,
  rpxy_chan_if.source  out_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  trig_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign in_i.ready  = (count_q != CntW'(Depth));
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = mem_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  a_full_push_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(Depth)) && !pop |=> (count_q == CntW'(Depth)))
    else $error("queue lost an entry while full");

endmodule

[hw/rtl/rpxy_back.sv]
module rpxy_back import rpxy_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpxy_chan_if.sink    in_i,
  rpxy_chan_if.source  out_o
);

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  localparam acc_t SatHi = (AccW'(1) << (CoordW - 1)) - AccW'(1);
  localparam acc_t SatLo = -SatHi - AccW'(1);
  localparam acc_t RndA  = AccW'(1) << (TrigFrac - 1);
  localparam logic signed [2*TrigW-1:0] RndT = (2*TrigW)'(1) << (TrigFrac - 1);

  function automatic trig_t tmul(input trig_t a, input trig_t b);
    logic signed [2*TrigW-1:0] p;
    p = ((2*TrigW)'(a) * (2*TrigW)'(b) + RndT) >>> TrigFrac;
    return TrigW'(p);
  endfunction

  function automatic prod_t cmul(input coord_t a, input trig_t b);
    prod_t pa;
    prod_t pb;
    pa = ProdW'(a);
    pb = ProdW'(b);
    return pa * pb;
  endfunction

  function automatic coord_t finish(input acc_t acc);
    acc_t r;
    r = (acc + RndA) >>> TrigFrac;
    if (r > SatHi) begin
      r = SatHi;
    end else if (r < SatLo) begin
      r = SatLo;
    end
    return CoordW'(r);
  endfunction

  // stage 1: matrix terms
  trig_item_t s1_q;
  trig_t      m01_q, m02_q, m21_q, m22_q;
  // stage 2: products
  prod_t      p_xcb_q, p_ym01_q, p_zm02_q, p_yca_q, p_zsa_q, p_xsb_q, p_ym21_q, p_zm22_q;
  // stage 3: results
  out_item_t  res_q;
  logic [2:0] vld_q;
  logic       adv;

  assign adv         = !vld_q[2] || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = vld_q[2];
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[1:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= in_i.data;
      m01_q <= tmul(in_i.data.sa, in_i.data.sb);
      m02_q <= tmul(in_i.data.ca, in_i.data.sb);
      m21_q <= tmul(in_i.data.sa, in_i.data.cb);
      m22_q <= tmul(in_i.data.ca, in_i.data.cb);

      p_xcb_q  <= cmul(s1_q.point_x, s1_q.cb);
      p_ym01_q <= cmul(s1_q.point_y, m01_q);
      p_zm02_q <= cmul(s1_q.point_z, m02_q);
      p_yca_q  <= cmul(s1_q.point_y, s1_q.ca);
      p_zsa_q  <= cmul(s1_q.point_z, s1_q.sa);
      p_xsb_q  <= cmul(s1_q.point_x, s1_q.sb);
      p_ym21_q <= cmul(s1_q.point_y, m21_q);
      p_zm22_q <= cmul(s1_q.point_z, m22_q);

      res_q.rotated_x <= finish(AccW'(p_xcb_q) + AccW'(p_ym01_q) + AccW'(p_zm02_q));
      res_q.rotated_y <= finish(AccW'(p_yca_q) - AccW'(p_zsa_q));
      res_q.rotated_z <= finish(AccW'(p_ym21_q) + AccW'(p_zm22_q) - AccW'(p_xsb_q));
    end
  end

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !vld_q[1] |=> !out_o.valid)
    else $error("result appeared without an item behind it");

endmodule

[hw/rtl/rotate_point_about_x_then_y.sv]
// Channel   Dir  Payload                                            Accepted when
// in_i      in   point_x/y/z (Q16.16), angle_alpha, angle_beta       in_i.valid && in_i.ready
// out_o     out  rotated_x/y/z (Q16.16, saturated)                   out_o.valid && out_o.ready
//
// One item per cycle sustained while out_o.ready holds; a 26-stage CORDIC front, a registered
// queue, then three back stages for matrix terms, products, sums.
// Reset clears only valid bits, queue pointers and the queue count; payload registers are not reset.
// The front stalls only when its last stage is blocked by a full queue; the back
// stalls only when its result is not taken. The queue absorbs the difference.
module rotate_point_about_x_then_y import rpxy_pkg::*; #(
  parameter int FIFO_DEPTH = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpxy_chan_if.sink   in_i,
  rpxy_chan_if.source out_o
);

  // Front to queue, queue to back
  rpxy_chan_if #(.T(trig_item_t)) push_if ();
  rpxy_chan_if #(.T(trig_item_t)) pop_if ();

  // Produce sine and cosine of both angles, carry the point alongside
  rpxy_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (push_if)
  );

  // Hold trig items so either side can stall on its own
  rpxy_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (push_if),
    .out_o  (pop_if)
  );

  // Build the rotation matrix, apply it, round and saturate
  rpxy_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pop_if),
    .out_o  (out_o)
  );

endmodule

[dv/rpxy_tb_pkg.sv]
package rpxy_tb_pkg;
  import rpxy_pkg::*;

  localparam int ElemIters = 24;
  localparam longint SinGain = 652032874;

  localparam longint ArcTab [ElemIters] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680350, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Shift right with rounding toward minus infinity.
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint to_q16(longint v);
    longint r;
    if (v > -(64'sd1 <<< 14) && v < (64'sd1 <<< 14)) return 0;
    r = asr(v + (64'sd1 <<< 13), 14);
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  // Rotate-mode CORDIC on a binary angle, folded back to all four quadrants.
  function automatic void angle_trig(logic [15:0] ang, output longint co, output longint si);
    logic [31:0] a;
    logic [1:0] q;
    logic [31:0] ru;
    longint x, y, z, dx, dy, c, s;
    a = {ang, 16'h0};
    q = 2'((a + 32'h2000_0000) >> 30);
    ru = a - ({30'd0, q} << 30);
    z = longint'($signed(ru));
    x = SinGain;
    y = 0;
    for (int i = 0; i < ElemIters; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    c = to_q16(x);
    s = to_q16(y);
    case (q)
      2'd0: begin co = c; si = s; end
      2'd1: begin co = -s; si = c; end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic longint trig_prod(longint a, longint b);
    return asr(a * b + 32768, 16);
  endfunction

  function automatic coord_t round_sat(longint acc);
    longint r;
    r = asr(acc + 32768, 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return coord_t'(r);
  endfunction

  function automatic out_item_t rotate_xy(in_item_t p);
    longint x, y, z, ca, sa, cb, sb;
    out_item_t o;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    z = longint'(p.point_z);
    angle_trig(p.angle_alpha, ca, sa);
    angle_trig(p.angle_beta, cb, sb);
    o.rotated_x = round_sat(x * cb + y * trig_prod(sa, sb) + z * trig_prod(ca, sb));
    o.rotated_y = round_sat(y * ca - z * sa);
    o.rotated_z = round_sat(-x * sb + y * trig_prod(sa, cb) + z * trig_prod(ca, cb));
    return o;
  endfunction
endpackage

[dv/tb.sv]
module tb;
  import rpxy_pkg::*;
  import rpxy_tb_pkg::*;

  localparam int Latency = 30;
  localparam int StallLimit = 4000;
  localparam int NumRandom = 530;
  localparam logic [15:0] Quarter = 16'h4000;
  localparam logic [15:0] Half = 16'h8000;
  localparam coord_t CMax = 32'sh7fff_ffff;
  localparam coord_t CMin = 32'sh8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rpxy_chan_if #(.T(in_item_t)) pt_ch ();
  rpxy_chan_if #(.T(out_item_t)) rot_ch ();

  rotate_point_about_x_then_y dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pt_ch.sink),
    .out_o (rot_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One directed row: the point, and optionally a result typed in by hand.
  typedef struct {
    in_item_t  pt;
    bit        known;
    out_item_t want;
  } row_t;

  out_item_t rotated_q[$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_got = 0;
  int        n_sat = 0;
  int        idle_cycles = 0;
  bit        sender_done = 1'b0;
  bit        hold_sink = 1'b0;

  task automatic report_error(string msg);
    n_errors++;
    $display("MISMATCH %s", msg);
  endtask

  task automatic report_mismatch(string what, coord_t got, coord_t want);
    report_error($sformatf("item %0d %s: got %0d expected %0d", n_got, what, got, want));
  endtask

  function automatic in_item_t mk(coord_t x, coord_t y, coord_t z, logic [15:0] a,
                                  logic [15:0] b);
    in_item_t p;
    p.point_x = x; p.point_y = y; p.point_z = z;
    p.angle_alpha = a; p.angle_beta = b;
    return p;
  endfunction

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return $urandom_range(0, 1) ? CMax : CMin;
      2: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return coord_t'($urandom) >>> $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic [15:0] rnd_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) * Quarter + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_point(in_item_t p);
    pt_ch.valid <= 1'b1;
    pt_ch.data  <= p;
    do @(posedge clk_i); while (!pt_ch.ready);
    rotated_q.push_back(rotate_xy(p));
    n_sent++;
  endtask

  task automatic go_idle(int n);
    pt_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sender: directed table first, a run against a held-off receiver, then random bursts with random gaps.
  initial begin
    row_t rows[$];
    row_t r;
    int burst;
    pt_ch.valid = 1'b0;
    pt_ch.data  = '0;
    r.known = 1'b1;
    // zero rotation passes the point through
    r.pt = mk(32'sd65536, -32'sd131072, 32'sd7, 16'd0, 16'd0);
    r.want = '{32'sd65536, -32'sd131072, 32'sd7};
    rows.push_back(r);
    r.pt = mk(CMax, CMin, 32'sd0, 16'd0, 16'd0);
    r.want = '{CMax, CMin, 32'sd0};
    rows.push_back(r);
    // quarter turn about x: y -> z, z -> -y
    r.pt = mk(32'sd5, 32'sd65536, 32'sd0, Quarter, 16'd0);
    r.want = '{32'sd5, 32'sd0, 32'sd65536};
    rows.push_back(r);
    // half turn about y on the most negative x saturates
    r.pt = mk(CMin, 32'sd0, 32'sd0, 16'd0, Half);
    r.want = '{CMax, 32'sd0, 32'sd0};
    rows.push_back(r);
    r.known = 1'b0;
    rows.push_back('{mk(CMax, CMax, CMax, 16'hffff, 16'hffff), 1'b0, '0});
    rows.push_back('{mk(CMin, CMin, CMin, 16'h0001, 16'h0001), 1'b0, '0});
    rows.push_back('{mk(CMax, CMax, CMin, 16'h2000, 16'h2000), 1'b0, '0});
    rows.push_back('{mk(CMin, CMax, CMax, 16'hc000, 16'h4000), 1'b0, '0});
    rows.push_back('{mk(32'sd1, -32'sd1, 32'sd1, 16'h3fff, 16'h4001), 1'b0, '0});
    rows.push_back('{mk(32'sd65536, 32'sd65536, 32'sd65536, Half, Quarter), 1'b0, '0});
    rows.push_back('{mk(-32'sd1, 32'sd0, 32'sd0, 16'h7fff, 16'hbfff), 1'b0, '0});
    rows.push_back('{mk(32'sd12345, -32'sd54321, 32'sd99999, 16'hc001, 16'h5555), 1'b0, '0});
    rows.push_back('{mk(CMax, CMin, CMax, 16'haaaa, 16'h8001), 1'b0, '0});
    rows.push_back('{mk(32'sd0, 32'sd0, 32'sd0, 16'h1234, 16'hfedc), 1'b0, '0});
    rows.push_back('{mk(32'sd3, 32'sd3, 32'sd3, 16'h0002, 16'hfffe), 1'b0, '0});

    wait (rst_ni);
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].known && rotate_xy(rows[i].pt) != rows[i].want)
        report_error($sformatf("directed row %0d disagrees with hand value", i));
      send_point(rows[i].pt);
    end
    // pause until the pipe drains
    go_idle(0);
    wait (rotated_q.size() == 0);
    @(posedge clk_i);
    // keep offering while the receiver holds off for a long stretch
    hold_sink = 1'b1;
    for (int i = 0; i < 60; i++) send_point(mk(rnd_coord(), rnd_coord(), rnd_coord(),
                                              rnd_angle(), rnd_angle()));
    hold_sink = 1'b0;
    for (int n = 0; n < NumRandom - 60; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++, n++)
        send_point(mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_angle(), rnd_angle()));
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 12));
    end
    pt_ch.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: own stall pattern, with one long forced hold-off.
  initial begin
    int held;
    rot_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink && held < 200) begin
        held++;
        rot_ch.ready <= 1'b0;
      end else if ((n_got / 64) % 2 == 0) begin
        rot_ch.ready <= 1'b1;
      end else begin
        rot_ch.ready <= ($urandom_range(0, 9) < 6);
      end
    end
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rot_ch.valid && rot_ch.ready) begin
      out_item_t want;
      if (rotated_q.size() == 0) begin
        report_error("unexpected result item");
      end else begin
        want = rotated_q.pop_front();
        if (rot_ch.data.rotated_x !== want.rotated_x)
          report_mismatch("rotated_x", rot_ch.data.rotated_x, want.rotated_x);
        if (rot_ch.data.rotated_y !== want.rotated_y)
          report_mismatch("rotated_y", rot_ch.data.rotated_y, want.rotated_y);
        if (rot_ch.data.rotated_z !== want.rotated_z)
          report_mismatch("rotated_z", rot_ch.data.rotated_z, want.rotated_z);
        if (want.rotated_x inside {CMax, CMin} || want.rotated_z inside {CMax, CMin})
          n_sat++;
      end
      n_got++;
    end
  end

  // Watchdog: count cycles with no item accepted on either side.
  always @(posedge clk_i) begin
    if ((pt_ch.valid && pt_ch.ready) || (rot_ch.valid && rot_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (sender_done && rotated_q.size() == 0);
        repeat (Latency + 10) @(posedge clk_i);
      end
      wait (idle_cycles >= StallLimit);
    join_any
    if (idle_cycles >= StallLimit || rotated_q.size() != 0) begin
      $display("Timeout with %0d results outstanding", rotated_q.size());
      $display("Testbench completed WITH ERRORS");
    end else begin
      $display("Sent %0d points, checked %0d rotations, %0d near saturation", n_sent, n_got,
               n_sat);
      if (n_errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/rpxy_pkg.sv
hw/rtl/rpxy_chan_if.sv
hw/rtl/rpxy_front.sv
hw/rtl/rpxy_fifo.sv
hw/rtl/rpxy_back.sv
hw/rtl/rotate_point_about_x_then_y.sv
dv/rpxy_tb_pkg.sv
dv/tb.sv
